/* rtl/core/plc_pkg.sv */
package plc_pkg;

  localparam int RANGE_COUNT   = 4;
  localparam int LIGHT_LEVELS  = 7;
  localparam int TABLE_LEVELS  = 7;
  localparam int MAX_STEPS     = 3;
  localparam int MIN_BASE_DIFF = 100;
  localparam int RANGE_MARGIN  = 400;
  localparam int ADC_FULL      = 4096;
  localparam logic [11:0] SAMPLE_MAX = 12'hFFF;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // level reported when no edge is above the sample
  localparam int DEFAULT_LEVEL =
    (LIGHT_LEVELS - 1 >= TABLE_LEVELS) ? TABLE_LEVELS - 1 : LIGHT_LEVELS - 1;

  typedef enum logic [1:0] {
    MODE_IR      = 2'd0,
    MODE_PROX    = 2'd1,
    MODE_LIGHT   = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIST_CLOSE = 2'd0,
    DIST_FAR   = 2'd1,
    DIST_NONE  = 2'd2
  } dist_t;

  typedef enum logic [1:0] {
    REG_ADAPTIVE   = 2'd0,
    REG_NEAR       = 2'd1,
    REG_FAR        = 2'd2,
    REG_LIGHT_EDGE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        is_light;
    logic [1:0]  distance;
    logic [13:0] lux;
    logic        light_invalid;
    logic        remeasure_ir;
    logic [1:0]  gain_range;
  } result_t;

  localparam logic [11:0] LOW_BOUND   [4] = '{12'd500, 12'd225, 12'd55, 12'd20};
  localparam logic [11:0] HIGH_BOUND  [4] = '{12'd650, 12'd260, 12'd75, 12'd27};
  localparam logic [12:0] ERROR_BOUND [4] = '{13'd4096, 13'd1000, 13'd250, 13'd60};

  localparam logic [13:0] LUX_TAB [TABLE_LEVELS] =
    '{14'd10, 14'd225, 14'd320, 14'd640, 14'd1280, 14'd2600, 14'd10240};
  localparam logic [11:0] EDGE_TAB [TABLE_LEVELS] =
    '{12'd5, 12'd20, 12'd32, 12'd64, 12'd256, 12'd640, 12'd1024};

  // IR level above which the gain range steps up
  function automatic logic [11:0] ir_step_limit(input logic [1:0] r);
    ir_step_limit = 12'(ADC_FULL - int'(HIGH_BOUND[r]) - RANGE_MARGIN);
  endfunction

  function automatic dist_t classify(input logic signed [13:0] v,
                                     input logic [11:0] hi,
                                     input logic [11:0] lo);
    if (v > $signed({2'b00, hi})) begin
      classify = DIST_CLOSE;
    end else if (v < $signed({2'b00, lo})) begin
      classify = DIST_FAR;
    end else begin
      classify = DIST_NONE;
    end
  endfunction

  // first edge above the sample; lower edges win
  function automatic logic [2:0] light_level(input logic [11:0] s,
                                             input logic [11:0] first_edge);
    logic [2:0] lvl;
    lvl = 3'(DEFAULT_LEVEL);
    for (int i = TABLE_LEVELS - 1; i >= 0; i--) begin
      if (i < LIGHT_LEVELS) begin
        if (s < ((i == 0) ? first_edge : EDGE_TAB[i])) begin
          lvl = 3'(i);
        end
      end
    end
    light_level = lvl;
  endfunction

endpackage

/* rtl/core/plc_if.sv */
interface plc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface plc_out_if;
  logic        valid;
  logic        ready;
  logic        is_light;
  logic [1:0]  distance;
  logic [13:0] lux;
  logic        light_invalid;
  logic        remeasure_ir;
  logic [1:0]  gain_range;

  modport source (output valid, output is_light, output distance, output lux,
                  output light_invalid, output remeasure_ir, output gain_range,
                  input ready);
  modport sink   (input valid, input is_light, input distance, input lux,
                  input light_invalid, input remeasure_ir, input gain_range,
                  output ready);
endinterface

/* rtl/core/proximity_light_classifier_core.sv */
// Proximity and ambient light classifier. Each input transfer is an IR,
// proximity or light sample (clamped to 4095) or a session restart; it yields
// at most one result transfer. The whole decision is combinational logic
// between the input and a result register, so one item is taken every cycle
// unless input stalls; a result that meets a held result waits in the skid
// register. This two-entry output queue (result register plus skid register)
// keeps input flowing for one more item while a result waits; input stalls
// only when both are full. Configuration registers sit on the APB port at 0x0
// adaptive_mode, 0x4 near_threshold, 0x8 far_threshold, 0xC lowest_light_edge;
// write them only while no item is in flight.
module proximity_light_classifier_core (
  input  logic                        clk,
  input  logic                        rst,
  plc_in_if.sink                      in_ch,
  plc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plc_pkg::ADDR_W-1:0]  paddr,
  input  logic [plc_pkg::DATA_W-1:0]  pwdata,
  output logic [plc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import plc_pkg::*;

  // configuration
  logic        adaptive_mode;
  logic [11:0] near_threshold;
  logic [11:0] far_threshold;
  logic [11:0] lowest_light_edge;

  // classifier state
  logic [11:0] last_ir;
  logic [1:0]  range_level;
  logic [1:0]  step_count;
  dist_t       previous_decision;
  logic        awaiting_baseline;
  logic [11:0] baseline;
  logic        light_first;

  logic [11:0] last_ir_next;
  logic [1:0]  range_level_next;
  logic [1:0]  step_count_next;
  dist_t       previous_decision_next;
  logic        awaiting_baseline_next;
  logic [11:0] baseline_next;
  logic        light_first_next;

  // output queue
  logic        out_valid;
  result_t     out_data;
  logic        skid_valid;
  result_t     skid_data;

  logic        accept;
  logic        pop;
  logic        emit;
  result_t     res;
  logic [11:0] samp;
  logic signed [12:0] diff;
  logic signed [13:0] rel;
  logic signed [13:0] diff_ext;
  dist_t       dec;
  logic        step_up;
  logic        in_bounds;
  reg_idx_t    reg_sel;
  logic        cfg_write;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_mode     <= 1'b1;
      near_threshold    <= 12'd180;
      far_threshold     <= 12'd170;
      lowest_light_edge <= 12'd5;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_ADAPTIVE:   adaptive_mode     <= pwdata[0];
        REG_NEAR:       near_threshold    <= pwdata[11:0];
        REG_FAR:        far_threshold     <= pwdata[11:0];
        REG_LIGHT_EDGE: lowest_light_edge <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ADAPTIVE:   prdata = {{(DATA_W-1){1'b0}}, adaptive_mode};
      REG_NEAR:       prdata = {{(DATA_W-12){1'b0}}, near_threshold};
      REG_FAR:        prdata = {{(DATA_W-12){1'b0}}, far_threshold};
      REG_LIGHT_EDGE: prdata = {{(DATA_W-12){1'b0}}, lowest_light_edge};
      default:        prdata = '0;
    endcase
  end

  // ---------------- classification ----------------
  assign in_ch.ready = !skid_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_valid && out_ch.ready;

  assign samp      = (|in_ch.sample[15:12]) ? SAMPLE_MAX : in_ch.sample[11:0];
  assign diff      = $signed({1'b0, samp}) - $signed({1'b0, last_ir});
  assign diff_ext  = {diff[12], diff};
  assign rel       = diff_ext - $signed({2'b00, baseline});
  assign in_bounds = !diff[12] && ({1'b0, diff[11:0]} <= ERROR_BOUND[range_level]);
  assign step_up   = adaptive_mode && (samp > ir_step_limit(range_level)) &&
                     (step_count < 2'(MAX_STEPS)) &&
                     (range_level < 2'(RANGE_COUNT - 1));

  always_comb begin
    last_ir_next           = last_ir;
    range_level_next       = range_level;
    step_count_next        = step_count;
    previous_decision_next = previous_decision;
    awaiting_baseline_next = awaiting_baseline;
    baseline_next          = baseline;
    light_first_next       = light_first;
    emit                   = 1'b0;
    dec                    = DIST_NONE;
    res                    = '0;

    case (mode_t'(in_ch.mode))
      MODE_IR: begin
        last_ir_next = samp;
        if (step_up) begin
          range_level_next = range_level + 2'd1;
          step_count_next  = step_count + 2'd1;
          emit             = 1'b1;
          res.remeasure_ir = 1'b1;
        end
      end
      MODE_PROX: begin
        if (!adaptive_mode) begin
          dec          = classify(diff_ext, near_threshold, far_threshold);
          emit         = 1'b1;
          res.distance = dec;
        end else begin
          if (range_level == 2'd0) begin
            if (awaiting_baseline) begin
              if (diff >= 13'sd100) begin
                // captured baseline makes the relative value zero
                baseline_next          = diff[11:0];
                awaiting_baseline_next = 1'b0;
                dec = classify(14'sd0, near_threshold, far_threshold);
              end
            end else begin
              dec = classify(rel, near_threshold, far_threshold);
            end
          end else if (in_bounds) begin
            dec = classify(diff_ext, HIGH_BOUND[range_level], LOW_BOUND[range_level]);
          end
          previous_decision_next = dec;
          emit = (dec == DIST_FAR) ||
                 (dec == DIST_CLOSE && previous_decision == DIST_CLOSE);
          res.distance = dec;
        end
      end
      MODE_LIGHT: begin
        emit         = 1'b1;
        res.is_light = 1'b1;
        if (light_first) begin
          light_first_next  = 1'b0;
          res.light_invalid = 1'b1;
        end else begin
          res.lux = LUX_TAB[light_level(samp, lowest_light_edge)];
        end
      end
      MODE_RESTART: begin
        awaiting_baseline_next = 1'b1;
        baseline_next          = '0;
        if (adaptive_mode) begin
          light_first_next       = 1'b1;
          range_level_next       = '0;
          step_count_next        = '0;
          previous_decision_next = DIST_NONE;
        end
      end
      default: ;
    endcase

    res.gain_range = range_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ir           <= '0;
      range_level       <= '0;
      step_count        <= '0;
      previous_decision <= DIST_NONE;
      awaiting_baseline <= 1'b1;
      baseline          <= '0;
      light_first       <= 1'b1;
    end else if (accept) begin
      last_ir           <= last_ir_next;
      range_level       <= range_level_next;
      step_count        <= step_count_next;
      previous_decision <= previous_decision_next;
      awaiting_baseline <= awaiting_baseline_next;
      baseline          <= baseline_next;
      light_first       <= light_first_next;
    end
  end

  // ---------------- output queue ----------------
  // skid only fills when the result register is held; input is blocked
  // while skid is full, so a new result never meets a full skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (out_valid && !pop && !skid_valid) begin
      skid_data <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.is_light      = out_data.is_light;
  assign out_ch.distance      = out_data.distance;
  assign out_ch.lux           = out_data.lux;
  assign out_ch.light_invalid = out_data.light_invalid;
  assign out_ch.remeasure_ir  = out_data.remeasure_ir;
  assign out_ch.gain_range    = out_data.gain_range;

endmodule

/* rtl/core/plc_checker.sv */
module plc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_light,
  input logic [1:0]  distance,
  input logic [13:0] lux,
  input logic        light_invalid,
  input logic        remeasure_ir,
  input logic [1:0]  gain_range
);
  import plc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_light) &&
      $stable(distance) && $stable(lux) && $stable(light_invalid) &&
      $stable(remeasure_ir) && $stable(gain_range))
    else $error("result changed while stalled");

  // a range request always reports a stepped-up range and no other payload
  a_range_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && remeasure_ir |-> !is_light && distance == DIST_CLOSE &&
      lux == 14'd0 && !light_invalid && gain_range != 2'd0)
    else $error("malformed range request");

  // light report: no distance, invalid report carries no lux
  a_light: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_light |-> distance == DIST_CLOSE && !remeasure_ir &&
      (!light_invalid || lux == 14'd0))
    else $error("malformed light report");

  // distance report carries a legal code and no light fields
  a_distance: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_light && !remeasure_ir |-> lux == 14'd0 && !light_invalid &&
      (distance == DIST_CLOSE || distance == DIST_FAR || distance == DIST_NONE))
    else $error("malformed distance report");

endmodule

bind proximity_light_classifier_core plc_checker u_plc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .is_light      (out_ch.is_light),
  .distance      (out_ch.distance),
  .lux           (out_ch.lux),
  .light_invalid (out_ch.light_invalid),
  .remeasure_ir  (out_ch.remeasure_ir),
  .gain_range    (out_ch.gain_range)
);
